// ===== sv/sem_pkg.sv =====
`default_nettype none

package sem_pkg;

  // Register and field widths
  localparam int CFG_DATA_W = 12;
  localparam int FW_W       = 11;
  localparam int FH_W       = 12;
  localparam int IN_ROW_W   = 13;
  localparam int OUT_ROW_W  = 12;
  localparam int MAG_W      = 11;

  // Smallest frame dimension the window logic accepts
  localparam int MIN_DIM = 3;

  localparam logic [MAG_W-1:0] MAG_MAX         = 11'd2047;
  localparam logic [FW_W-1:0]  FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FH_W-1:0]  FRAME_HEIGHT_RST = 12'd480;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_t;

endpackage

`default_nettype wire

// ===== sv/sem_in_if.sv =====
`default_nettype none

interface sem_in_if #(
  parameter int PIXEL_BITS = 8
);
  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [PIXEL_BITS-1:0] pixel;

  modport source (output valid, action, pixel, input ready);
  modport sink   (input valid, action, pixel, output ready);
endinterface

`default_nettype wire

// ===== sv/sem_out_if.sv =====
`default_nettype none

interface sem_out_if;
  import sem_pkg::*;

  logic             valid;
  logic             ready;
  logic             out_valid;
  logic [MAG_W-1:0] magnitude;
  logic             frame_last;

  modport source (output valid, out_valid, magnitude, frame_last, input ready);
  modport sink   (input valid, out_valid, magnitude, frame_last, output ready);
endinterface

`default_nettype wire

// ===== sv/sobel_edge_magnitude.sv =====
`default_nettype none

// Sobel edge magnitude over a raster-order grayscale stream. Each transferred item
// (a pixel, or a padding item after the frame) gives exactly one result: |Gx|+|Gy|
// of the pixel W+1 places earlier, 0 on the frame border; the first W+1 results of
// a frame carry out_valid low, and frame_last marks the final pixel, after which
// all position counters restart. W+1 padding items flush a frame. The block takes
// one item per clock unless the output stalls or the line store is clearing;
// a result passes through the stage 1, stage 2 and output registers. The rate is
// set by the line store, one synchronous memory of MAX_WIDTH entries holding the
// two previous rows per column: each item reads its column on transfer and writes
// it back as it leaves stage 1, with forwarding when two items in a row touch the
// same column. After reset a clearing pass zeroes every line store entry, during
// which in_chan.ready stays low; configuration writes are taken throughout.
module sobel_edge_magnitude #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  sem_in_if.sink                               in_chan,
  sem_out_if.source                            out_chan,
  input  wire logic                            cfg_we,
  input  wire sem_pkg::cfg_idx_t               cfg_index,
  input  wire logic [sem_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import sem_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int XW = (WW > FW_W) ? WW : FW_W;
  localparam int P  = PIXEL_BITS;
  localparam int GW = P + 3;
  localparam int MW = (GW > MAG_W) ? GW : MAG_W;

  typedef struct packed {
    logic res_valid;
    logic border;
    logic last;
  } flags_t;

  // ---------------------------------------------------------------- config
  logic [FW_W-1:0] frame_width_r;
  logic [FH_W-1:0] frame_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[FW_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the frame size to what the line store supports
  logic [XW-1:0]   fw_x;
  logic [WW-1:0]   w_eff;
  logic [WW-1:0]   w_m1;
  logic [FH_W-1:0] h_eff;
  logic [FH_W-1:0] h_m1;

  always_comb begin
    fw_x = XW'(frame_width_r);
    if (fw_x < XW'(MIN_DIM)) begin
      w_eff = WW'(MIN_DIM);
    end else if (fw_x > XW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fw_x);
    end
    h_eff = (frame_height_r < FH_W'(MIN_DIM)) ? FH_W'(MIN_DIM) : frame_height_r;
    w_m1  = w_eff - WW'(1);
    h_m1  = h_eff - FH_W'(1);
  end

  // ------------------------------------------------------------- handshake
  logic s1_v_r, s2_v_r, o_v_r;
  logic o_ready, s2_ready, s1_ready;
  logic lb_busy;
  logic acc;

  assign o_ready       = !o_v_r || out_chan.ready;
  assign s2_ready      = !s2_v_r || o_ready;
  assign s1_ready      = !s1_v_r || s2_ready;
  assign in_chan.ready = s1_ready && !lb_busy;
  assign acc           = in_chan.valid && in_chan.ready;

  // ------------------------------------------------ stage 0: position logic
  logic [CW-1:0]        in_col_r,  in_col_nxt;
  logic [IN_ROW_W-1:0]  in_row_r,  in_row_nxt;
  logic [CW-1:0]        out_col_r, out_col_nxt;
  logic [OUT_ROW_W-1:0] out_row_r, out_row_nxt;
  flags_t               s0_flags;
  logic                 s0_we;
  logic [P-1:0]         s0_pix;

  always_comb begin
    s0_flags.res_valid = (in_row_r >= IN_ROW_W'(2)) ||
                         (in_row_r == IN_ROW_W'(1) && in_col_r != '0);
    s0_flags.border    = (out_row_r == '0) || (out_row_r >= h_m1) ||
                         (out_col_r == '0) || (WW'(out_col_r) >= w_m1);
    s0_flags.last      = s0_flags.res_valid && (out_row_r >= h_m1) &&
                         (WW'(out_col_r) >= w_m1);
    s0_we              = in_row_r < IN_ROW_W'(h_eff);
    s0_pix             = in_chan.action ? '0 : P'(in_chan.pixel);

    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (acc) begin
      // Advance the input position
      if (WW'(in_col_r) + WW'(1) >= w_eff) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + IN_ROW_W'(1);
      end else begin
        in_col_nxt = in_col_r + CW'(1);
      end
      // Advance the output position, or restart the frame after its last pixel
      if (s0_flags.last) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end else if (s0_flags.res_valid) begin
        if (WW'(out_col_r) + WW'(1) >= w_eff) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + OUT_ROW_W'(1);
        end else begin
          out_col_nxt = out_col_r + CW'(1);
        end
      end
    end
  end

  flags_t        s1_flags_r;
  logic          s1_we_r;
  logic [P-1:0]  s1_pix_r;
  logic [CW-1:0] s1_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      s1_v_r    <= 1'b0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      if (s1_ready) begin
        s1_v_r <= acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_flags_r <= s0_flags;
      s1_we_r    <= s0_we;
      s1_pix_r   <= s0_pix;
      s1_idx_r   <= in_col_r;
    end
  end

  // ------------------------------------------- stage 1: line store and window
  logic [2*P-1:0] lb_rd;
  logic [2*P-1:0] lb_wd;
  logic           s1_adv;
  logic           lb_we;

  assign s1_adv = s1_v_r && s2_ready;
  assign lb_we  = s1_adv && s1_we_r;
  assign lb_wd  = {lb_rd[P-1:0], s1_pix_r};

  sem_linebuf #(
    .DEPTH (MAX_WIDTH),
    .DW    (2 * P)
  ) u_linebuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr_busy (lb_busy),
    .rd_en    (acc),
    .rd_addr  (in_col_r),
    .rd_data  (lb_rd),
    .wr_en    (lb_we),
    .wr_addr  (s1_idx_r),
    .wr_data  (lb_wd)
  );

  logic [3*P-1:0] win_l_r, win_c_r, win_r_r;
  logic [3*P-1:0] column;
  logic [3*P-1:0] wl, wc, wr;
  logic [P+1:0]   sum_l, sum_r, sum_t, sum_b;
  logic signed [GW-1:0] gx, gy;

  // Window as it stands once this item's column has shifted in
  always_comb begin
    column = {lb_rd, s1_pix_r};
    if (s1_we_r) begin
      wl = win_c_r;
      wc = win_r_r;
      wr = column;
    end else begin
      wl = win_l_r;
      wc = win_c_r;
      wr = win_r_r;
    end
    // Top tap in the high bits, bottom (newest) in the low bits
    sum_r = (P+2)'(wr[3*P-1:2*P]) + ((P+2)'(wr[2*P-1:P]) << 1) + (P+2)'(wr[P-1:0]);
    sum_l = (P+2)'(wl[3*P-1:2*P]) + ((P+2)'(wl[2*P-1:P]) << 1) + (P+2)'(wl[P-1:0]);
    sum_t = (P+2)'(wl[3*P-1:2*P]) + ((P+2)'(wc[3*P-1:2*P]) << 1) +
            (P+2)'(wr[3*P-1:2*P]);
    sum_b = (P+2)'(wl[P-1:0]) + ((P+2)'(wc[P-1:0]) << 1) + (P+2)'(wr[P-1:0]);
    gx    = $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
    gy    = $signed({1'b0, sum_t}) - $signed({1'b0, sum_b});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_l_r <= '0;
      win_c_r <= '0;
      win_r_r <= '0;
    end else if (lb_we) begin
      win_l_r <= win_c_r;
      win_c_r <= win_r_r;
      win_r_r <= column;
    end
  end

  flags_t               s2_flags_r;
  logic signed [GW-1:0] s2_gx_r, s2_gy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_ready) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_flags_r <= s1_flags_r;
      s2_gx_r    <= gx;
      s2_gy_r    <= gy;
    end
  end

  // ------------------------------------------------ stage 2: magnitude
  logic [GW-2:0]    ax, ay;
  logic [GW-1:0]    msum;
  logic [MW-1:0]    msum_x;
  logic [MAG_W-1:0] mag;
  logic             s2_adv;

  assign s2_adv = s2_v_r && o_ready;

  always_comb begin
    ax     = s2_gx_r[GW-1] ? (GW-1)'(-s2_gx_r) : s2_gx_r[GW-2:0];
    ay     = s2_gy_r[GW-1] ? (GW-1)'(-s2_gy_r) : s2_gy_r[GW-2:0];
    msum   = GW'(ax) + GW'(ay);
    msum_x = MW'(msum);
    mag    = (msum_x > MW'(MAG_MAX)) ? MAG_MAX : msum_x[MAG_W-1:0];
  end

  // ------------------------------------------------ output register
  logic             o_res_valid_r;
  logic [MAG_W-1:0] o_mag_r;
  logic             o_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (o_ready) begin
      o_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      o_res_valid_r <= s2_flags_r.res_valid;
      o_mag_r       <= (s2_flags_r.res_valid && !s2_flags_r.border) ? mag : '0;
      o_last_r      <= s2_flags_r.last;
    end
  end

  assign out_chan.valid      = o_v_r;
  assign out_chan.out_valid  = o_res_valid_r;
  assign out_chan.magnitude  = o_mag_r;
  assign out_chan.frame_last = o_last_r;

  // ------------------------------------------------ assertions
  a_quiet_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.out_valid |->
      out_chan.magnitude == '0 && !out_chan.frame_last)
    else $error("result outside the output frame carries data");

  a_last_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.frame_last |-> out_chan.out_valid)
    else $error("frame end marked on a result outside the frame");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    acc && s0_flags.last |=>
      in_col_r == '0 && in_row_r == '0 && out_col_r == '0 && out_row_r == '0)
    else $error("position counters not restarted after frame end");

endmodule

`default_nettype wire

// ===== sv/sem_linebuf.sv =====
`default_nettype none

module sem_linebuf #(
  parameter int DEPTH = 1024,
  parameter int DW    = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  output logic                          clr_busy,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DW-1:0]                 rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [DW-1:0]            wr_data
);
  localparam int AW = $clog2(DEPTH);

  logic [DW-1:0] mem [DEPTH];

  logic [AW-1:0] clr_cnt_r;
  logic          clr_busy_r;
  logic [DW-1:0] q_r;
  logic [AW-1:0] rd_addr_r;
  logic          lw_v_r;
  logic [AW-1:0] lw_addr_r;
  logic [DW-1:0] lw_data_r;

  // Storage: clearing pass first, then write-back; read data registered
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r       <= mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
    if (!clr_busy_r && wr_en) begin
      lw_addr_r <= wr_addr;
      lw_data_r <= wr_data;
    end
  end

  // Sweep every entry to zero after reset; track the last write-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
      lw_v_r     <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          clr_busy_r <= 1'b0;
        end
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end else if (wr_en) begin
        lw_v_r <= 1'b1;
      end
    end
  end

  // Forward the latest write-back when it hit the entry being read
  assign rd_data  = (lw_v_r && lw_addr_r == rd_addr_r) ? lw_data_r : q_r;
  assign clr_busy = clr_busy_r;

endmodule

`default_nettype wire
